// File: rtl/core/dtf_pkg.sv
// shared constants, character codes, state encodings and the power-of-ten table
// for the decimal text to fixed point unit; no dependencies
package dtf_pkg;

  // default format and limits
  localparam int INT_BITS_DEF        = 16;
  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  // character width, fraction mantissa width (nine digits) and digit count width
  localparam int CHAR_W  = 8;
  localparam int MANT_W  = 30;
  localparam int CNT_W   = 4;
  localparam int DIGIT_W = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  // parser phases
  typedef enum logic [4:0] {
    PH_WS   = 5'b00001,
    PH_INT  = 5'b00010,
    PH_FRAC = 5'b00100,
    PH_TAIL = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  // divider states
  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_t;

  // 10^n for n = 0..9
  function automatic logic [MANT_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [MANT_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/dtf_if.sv
// valid/ready channel interfaces for character input and result output
// depends on dtf_pkg
interface dtf_char_if;
  logic                         valid;
  logic                         ready;
  logic [dtf_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dtf_res_if #(
  parameter int VALUE_W = dtf_pkg::INT_BITS_DEF + dtf_pkg::FRAC_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      valid_res;
  logic                      overflow;

  modport source (output valid, output value, output valid_res, output overflow,
                  input ready);
  modport sink   (input valid, input value, input valid_res, input overflow,
                  output ready);
endinterface

// File: rtl/core/decimal_text_to_fixed_point_unit.sv
// top level of the decimal text to fixed point unit
// depends on dtf_pkg, dtf_if, dtf_front, dtf_queue and dtf_back
//
// Reads a decimal number as text, one character per item, and returns one
// signed fixed point result (INT_BITS integer, FRAC_BITS fraction bits) with a
// strict format flag and an integer overflow flag for each string ended by
// byte 0. The parser takes one character per cycle while the queue has room.
// A terminator hands a job to a two-entry queue. The divider takes a job
// only when idle, produces the scaled fraction one quotient bit per cycle,
// loads the result register once the output is free and only then takes
// the next job; meanwhile later jobs wait in the queue, and the parser
// stalls whenever the queue is full.
module decimal_text_to_fixed_point_unit #(
  parameter int INT_BITS        = dtf_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dtf_char_if.sink  chars,
  dtf_res_if.source results
);

  localparam int JOB_W = INT_BITS - 1 + dtf_pkg::MANT_W + dtf_pkg::CNT_W + 3;

  logic             fq_valid, fq_ready;
  logic [JOB_W-1:0] fq_job;
  logic             qb_valid, qb_ready;
  logic [JOB_W-1:0] qb_job;

  // parser
  dtf_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .JOB_W           (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // job queue
  dtf_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  // divider and result register
  dtf_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .results   (results)
  );

endmodule

// File: rtl/core/dtf_front.sv
// character parser: classifies each item, accumulates integer and fraction
// digits and hands a job to the queue on the terminator; depends on dtf_pkg and dtf_if
module dtf_front #(
  parameter int INT_BITS        = dtf_pkg::INT_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int JOB_W           = INT_BITS - 1 + dtf_pkg::MANT_W + dtf_pkg::CNT_W + 3
) (
  input  logic             clk,
  input  logic             rst,
  dtf_char_if.sink         chars,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [JOB_W-1:0] job
);

  localparam int ACC_W = INT_BITS - 1;
  localparam int PRD_W = INT_BITS + 3;
  localparam logic [ACC_W-1:0] IMAX = '1;

  typedef struct packed {
    logic                         neg;
    logic [ACC_W-1:0]             acc;
    logic                         sat;
    logic [dtf_pkg::MANT_W-1:0]   mant;
    logic [dtf_pkg::CNT_W-1:0]    cnt;
    logic                         ok;
  } job_t;

  dtf_pkg::phase_t              phase, phase_next;
  logic                         neg, neg_next;
  logic [ACC_W-1:0]             acc, acc_next;
  logic                         sat, sat_next;
  logic [dtf_pkg::MANT_W-1:0]   mant, mant_next;
  logic [dtf_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic                         int_seen, int_seen_next;

  logic [dtf_pkg::CHAR_W-1:0]   c;
  logic                         accept;
  logic                         is_term, is_space, is_digit;
  logic [dtf_pkg::DIGIT_W-1:0]  d;
  logic [PRD_W-1:0]             int_prod;
  logic [dtf_pkg::MANT_W-1:0]   frac_prod;
  logic                         ok;
  job_t                         job_s;

  assign c           = chars.char_code;
  assign chars.ready = job_ready;
  assign accept      = chars.valid & job_ready;

  // character classes
  always_comb begin
    is_term  = (c == dtf_pkg::CH_NUL);
    is_space = (c == dtf_pkg::CH_SPACE) || (c inside {[dtf_pkg::CH_TAB:dtf_pkg::CH_CR]});
    is_digit = c inside {[dtf_pkg::CH_ZERO:dtf_pkg::CH_NINE]};
  end

  assign d = dtf_pkg::DIGIT_W'(c - dtf_pkg::CH_ZERO);

  // acc * 10 + d and mant * 10 + d as shift-adds
  assign int_prod  = PRD_W'({acc, 3'b000}) + PRD_W'({acc, 1'b0}) + PRD_W'(d);
  assign frac_prod = dtf_pkg::MANT_W'({mant, 3'b000}) + dtf_pkg::MANT_W'({mant, 1'b0})
                   + dtf_pkg::MANT_W'(d);

  // strict format check at the terminator
  always_comb begin
    case (phase)
      dtf_pkg::PH_INT:  ok = int_seen;
      dtf_pkg::PH_FRAC: ok = (cnt != '0);
      dtf_pkg::PH_TAIL: ok = 1'b1;
      default:          ok = 1'b0;
    endcase
  end

  // job handed to the divider
  always_comb begin
    job_s.neg  = neg;
    job_s.acc  = acc;
    job_s.sat  = sat;
    job_s.mant = mant;
    job_s.cnt  = cnt;
    job_s.ok   = ok;
  end

  assign job       = job_s;
  assign job_valid = chars.valid & is_term;

  // parser next state
  always_comb begin
    phase_next    = phase;
    neg_next      = neg;
    acc_next      = acc;
    sat_next      = sat;
    mant_next     = mant;
    cnt_next      = cnt;
    int_seen_next = int_seen;

    if (is_term) begin
      phase_next    = dtf_pkg::PH_WS;
      neg_next      = 1'b0;
      acc_next      = '0;
      sat_next      = 1'b0;
      mant_next     = '0;
      cnt_next      = '0;
      int_seen_next = 1'b0;
    end else begin
      case (phase)
        dtf_pkg::PH_WS: begin
          if (is_space) begin
            phase_next = dtf_pkg::PH_WS;
          end else if (c == dtf_pkg::CH_MINUS) begin
            neg_next   = 1'b1;
            phase_next = dtf_pkg::PH_INT;
          end else if (c == dtf_pkg::CH_PLUS) begin
            phase_next = dtf_pkg::PH_INT;
          end else if (is_digit) begin
            phase_next = dtf_pkg::PH_INT;
          end else if (c == dtf_pkg::CH_DOT) begin
            phase_next = dtf_pkg::PH_FRAC;
          end else begin
            phase_next = dtf_pkg::PH_SKIP;
          end
        end
        dtf_pkg::PH_INT: begin
          if (is_digit) begin
            phase_next = dtf_pkg::PH_INT;
          end else if (c == dtf_pkg::CH_DOT) begin
            phase_next = dtf_pkg::PH_FRAC;
          end else begin
            phase_next = dtf_pkg::PH_SKIP;
          end
        end
        dtf_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (cnt < dtf_pkg::CNT_W'(MAX_FRAC_DIGITS)) begin
              mant_next = frac_prod;
              cnt_next  = cnt + 1'b1;
            end
          end else if ((cnt != '0) && is_space) begin
            phase_next = dtf_pkg::PH_TAIL;
          end else begin
            phase_next = dtf_pkg::PH_SKIP;
          end
        end
        dtf_pkg::PH_TAIL: begin
          if (!is_space) begin
            phase_next = dtf_pkg::PH_SKIP;
          end
        end
        default: begin
          phase_next = dtf_pkg::PH_SKIP;
        end
      endcase

      // integer digit in the whitespace or integer phase, saturating
      if (is_digit && (phase == dtf_pkg::PH_WS || phase == dtf_pkg::PH_INT)) begin
        int_seen_next = 1'b1;
        if (int_prod > PRD_W'(IMAX)) begin
          acc_next = IMAX;
          sat_next = 1'b1;
        end else begin
          acc_next = ACC_W'(int_prod);
        end
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= dtf_pkg::PH_WS;
      neg      <= 1'b0;
      acc      <= '0;
      sat      <= 1'b0;
      mant     <= '0;
      cnt      <= '0;
      int_seen <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      neg      <= neg_next;
      acc      <= acc_next;
      sat      <= sat_next;
      mant     <= mant_next;
      cnt      <= cnt_next;
      int_seen <= int_seen_next;
    end
  end

endmodule

// File: rtl/core/dtf_queue.sv
// two-entry job queue between parser and divider
// no dependencies
module dtf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/dtf_back.sv
// fraction scaling by restoring division, sign application and result register
// depends on dtf_pkg and dtf_if
module dtf_back #(
  parameter int INT_BITS  = dtf_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF,
  parameter int JOB_W     = INT_BITS - 1 + dtf_pkg::MANT_W + dtf_pkg::CNT_W + 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [JOB_W-1:0] job,
  dtf_res_if.source        results
);

  localparam int ACC_W   = INT_BITS - 1;
  localparam int VALUE_W = INT_BITS + FRAC_BITS;
  localparam int ITER_W  = $clog2(FRAC_BITS);
  localparam int REM_W   = dtf_pkg::MANT_W;

  typedef struct packed {
    logic                         neg;
    logic [ACC_W-1:0]             acc;
    logic                         sat;
    logic [dtf_pkg::MANT_W-1:0]   mant;
    logic [dtf_pkg::CNT_W-1:0]    cnt;
    logic                         ok;
  } job_t;

  dtf_pkg::back_state_t state;
  job_t                 job_s;
  logic                 neg;
  logic [ACC_W-1:0]     acc;
  logic                 sat;
  logic                 ok;
  logic [REM_W-1:0]     divisor;
  logic [REM_W-1:0]     rem;
  logic [FRAC_BITS-1:0] quo;
  logic [ITER_W-1:0]    iter;

  logic [REM_W:0]       rem2;
  logic                 ge;
  logic [VALUE_W-1:0]   mag;
  logic [VALUE_W-1:0]   signed_val;
  logic                 out_free;

  assign job_s     = job;
  assign job_ready = (state == dtf_pkg::BK_IDLE);
  assign out_free  = !results.valid || results.ready;

  // one quotient bit per cycle
  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, divisor});

  // integer part and scaled fraction sit side by side, then the sign
  assign mag        = {1'b0, acc, quo};
  assign signed_val = neg ? (VALUE_W'(0) - mag) : mag;

  // divider sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtf_pkg::BK_IDLE;
      iter  <= '0;
    end else begin
      case (state)
        dtf_pkg::BK_IDLE: begin
          if (job_valid) begin
            iter  <= '0;
            state <= dtf_pkg::BK_DIV;
          end
        end
        dtf_pkg::BK_DIV: begin
          iter <= iter + 1'b1;
          if (iter == ITER_W'(FRAC_BITS - 1)) begin
            state <= dtf_pkg::BK_DONE;
          end
        end
        dtf_pkg::BK_DONE: begin
          if (out_free) begin
            state <= dtf_pkg::BK_IDLE;
          end
        end
        default: begin
          state <= dtf_pkg::BK_IDLE;
        end
      endcase
    end
  end

  // job and divider datapath
  always_ff @(posedge clk) begin
    if (state == dtf_pkg::BK_IDLE && job_valid) begin
      neg     <= job_s.neg;
      acc     <= job_s.acc;
      sat     <= job_s.sat;
      ok      <= job_s.ok;
      divisor <= dtf_pkg::pow10(job_s.cnt);
      rem     <= job_s.mant;
      quo     <= '0;
    end else if (state == dtf_pkg::BK_DIV) begin
      rem <= ge ? REM_W'(rem2 - {1'b0, divisor}) : REM_W'(rem2);
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == dtf_pkg::BK_DONE && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtf_pkg::BK_DONE && out_free) begin
      results.value     <= signed_val;
      results.valid_res <= ok;
      results.overflow  <= sat;
    end
  end

endmodule

// File: tb/decimal_text_to_fixed_point_unit_tb.sv
// self-checking testbench for the decimal text to fixed point unit
// depends on dtf_pkg, dtf_if and decimal_text_to_fixed_point_unit
// directed strings first, then random strings under several idle and stall mixes
module decimal_text_to_fixed_point_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = dtf_pkg::INT_BITS_DEF + dtf_pkg::FRAC_BITS_DEF;
  localparam int INT_MAX     = (1 << (dtf_pkg::INT_BITS_DEF - 1)) - 1;
  localparam int PHASE_ITEMS = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 64;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      valid_res;
    logic                      overflow;
  } fixed_result_t;

  typedef struct {
    string         text;
    bit            typed;
    fixed_result_t res;
  } directed_row_t;

  logic clk;
  logic rst;

  dtf_char_if            char_ch ();
  dtf_res_if #(VALUE_W)  res_ch ();

  decimal_text_to_fixed_point_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .results (res_ch)
  );

  // parser state of the predictor
  dtf_pkg::phase_t                   parse_phase;
  logic                              neg_sign;
  logic [dtf_pkg::INT_BITS_DEF-1:0]  int_acc;
  logic                              int_sat;
  logic [dtf_pkg::MANT_W-1:0]        frac_mant;
  logic [dtf_pkg::CNT_W-1:0]         frac_count;
  logic                              int_seen;
  logic                              fmt_err;

  fixed_result_t               pending_results[$];
  logic [dtf_pkg::CHAR_W-1:0]  line_chars[$];
  fixed_result_t               no_typed;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_toggle;
  int  fail_count;
  int  chars_sent;
  int  strings_sent;
  int  results_checked;
  int  well_formed_seen;
  int  overflow_seen;

  // strings with results typed in where they are obvious
  directed_row_t directed_rows[$] = '{
    '{"",            1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"0",           1'b1, '{48'h0000_0000_0000, 1'b1, 1'b0}},
    '{"12",          1'b1, '{48'h000C_0000_0000, 1'b1, 1'b0}},
    '{"-1",          1'b1, '{48'hFFFF_0000_0000, 1'b1, 1'b0}},
    '{"+7",          1'b1, '{48'h0007_0000_0000, 1'b1, 1'b0}},
    '{"32767",       1'b1, '{48'h7FFF_0000_0000, 1'b1, 1'b0}},
    '{"32768",       1'b1, '{48'h7FFF_0000_0000, 1'b1, 1'b1}},
    '{"-99999",      1'b1, '{48'h8001_0000_0000, 1'b1, 1'b1}},
    '{"12 ",         1'b1, '{48'h000C_0000_0000, 1'b0, 1'b0}},
    '{"12.",         1'b1, '{48'h000C_0000_0000, 1'b0, 1'b0}},
    '{".5",          1'b1, '{48'h0000_8000_0000, 1'b1, 1'b0}},
    '{" \011\012\013\014\0153.25\011 \015",
                     1'b1, '{48'h0003_4000_0000, 1'b1, 1'b0}},
    '{"1.5 ",        1'b1, '{48'h0001_8000_0000, 1'b1, 1'b0}},
    '{"1.5 7",       1'b1, '{48'h0001_8000_0000, 1'b0, 1'b0}},
    '{"12.5x",       1'b1, '{48'h000C_8000_0000, 1'b0, 1'b0}},
    '{"1-2",         1'b1, '{48'h0001_0000_0000, 1'b0, 1'b0}},
    '{"--5",         1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"- 5",         1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"abc",         1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"\377",        1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{".",           1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"   ",         1'b1, '{48'h0000_0000_0000, 1'b0, 1'b0}},
    '{"1.0000000001", 1'b0, '{48'h0, 1'b0, 1'b0}},
    '{"-0.999999999999", 1'b0, '{48'h0, 1'b0, 1'b0}},
    '{"-.75",        1'b0, '{48'h0, 1'b0, 1'b0}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("decimal_text_to_fixed_point_unit test failed");
    $finish;
  end

  function automatic void clear_parser();
    parse_phase = dtf_pkg::PH_WS;
    neg_sign    = 1'b0;
    int_acc     = '0;
    int_sat     = 1'b0;
    frac_mant   = '0;
    frac_count  = '0;
    int_seen    = 1'b0;
    fmt_err     = 1'b0;
  endfunction

  function automatic void abandon_number();
    parse_phase = dtf_pkg::PH_SKIP;
    fmt_err     = 1'b1;
  endfunction

  // integer digit with saturation at the largest magnitude
  function automatic void take_int_digit(input logic [dtf_pkg::CHAR_W-1:0] c);
    int unsigned acc;
    acc = 32'(int_acc) * 10 + 32'(c - dtf_pkg::CH_ZERO);
    if (acc > INT_MAX) begin
      acc     = INT_MAX;
      int_sat = 1'b1;
    end
    int_acc  = acc[dtf_pkg::INT_BITS_DEF-1:0];
    int_seen = 1'b1;
  endfunction

  // advances the parser by one character; a terminator yields the fixed point result
  function automatic void parse_char(input logic [dtf_pkg::CHAR_W-1:0] c, output bit done,
                                     output fixed_result_t r);
    logic [63:0] scale;
    logic [63:0] frac_part;
    logic [63:0] magnitude;
    logic [63:0] signed_mag;
    bit          space;
    bit          digit;
    space = (c == dtf_pkg::CH_SPACE) || (c >= dtf_pkg::CH_TAB && c <= dtf_pkg::CH_CR);
    digit = (c >= dtf_pkg::CH_ZERO) && (c <= dtf_pkg::CH_NINE);
    done  = 1'b0;
    r     = '{default: '0};
    if (c == dtf_pkg::CH_NUL) begin
      scale = 64'd1;
      for (int i = 0; i < frac_count; i++) scale = scale * 10;
      frac_part  = ({34'd0, frac_mant} << dtf_pkg::FRAC_BITS_DEF) / scale;
      magnitude  = ({48'd0, int_acc} << dtf_pkg::FRAC_BITS_DEF) + frac_part;
      signed_mag = neg_sign ? (64'd0 - magnitude) : magnitude;
      r.value    = signed_mag[VALUE_W-1:0];
      case (parse_phase)
        dtf_pkg::PH_INT:  r.valid_res = int_seen;
        dtf_pkg::PH_FRAC: r.valid_res = (frac_count != 0);
        dtf_pkg::PH_TAIL: r.valid_res = 1'b1;
        default:          r.valid_res = 1'b0;
      endcase
      if (fmt_err) r.valid_res = 1'b0;
      r.overflow = int_sat;
      done       = 1'b1;
      clear_parser();
    end else begin
      case (parse_phase)
        dtf_pkg::PH_WS: begin
          if (space) begin
          end else if (c == dtf_pkg::CH_MINUS) begin
            neg_sign    = 1'b1;
            parse_phase = dtf_pkg::PH_INT;
          end else if (c == dtf_pkg::CH_PLUS) begin
            parse_phase = dtf_pkg::PH_INT;
          end else if (digit) begin
            take_int_digit(c);
            parse_phase = dtf_pkg::PH_INT;
          end else if (c == dtf_pkg::CH_DOT) begin
            parse_phase = dtf_pkg::PH_FRAC;
          end else begin
            abandon_number();
          end
        end
        dtf_pkg::PH_INT: begin
          if (digit) take_int_digit(c);
          else if (c == dtf_pkg::CH_DOT) parse_phase = dtf_pkg::PH_FRAC;
          else abandon_number();
        end
        dtf_pkg::PH_FRAC: begin
          if (digit) begin
            // digits past the ninth only count for the format check
            if (frac_count < dtf_pkg::MAX_FRAC_DIGITS_DEF) begin
              frac_mant  = frac_mant * 10 + dtf_pkg::MANT_W'(c - dtf_pkg::CH_ZERO);
              frac_count = frac_count + 1'b1;
            end
          end else if (frac_count != 0 && space) begin
            parse_phase = dtf_pkg::PH_TAIL;
          end else begin
            abandon_number();
          end
        end
        dtf_pkg::PH_TAIL: begin
          if (!space) abandon_number();
        end
        default: begin
        end
      endcase
    end
  endfunction

  // one of the five control whitespace codes or a plain space
  function automatic logic [dtf_pkg::CHAR_W-1:0] pick_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? dtf_pkg::CH_SPACE : dtf_pkg::CH_TAB + dtf_pkg::CHAR_W'(r);
  endfunction

  function automatic logic [dtf_pkg::CHAR_W-1:0] pick_digit();
    return dtf_pkg::CH_ZERO + dtf_pkg::CHAR_W'($urandom_range(9));
  endfunction

  // mostly well-formed numbers with random content, some corrupted, some pure noise
  task automatic build_random_line();
    int kind;
    int n;
    line_chars.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(8);
      repeat (n) line_chars.push_back(dtf_pkg::CHAR_W'($urandom_range(255, 1)));
    end else begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) line_chars.push_back(pick_space());
      case ($urandom_range(3))
        0: line_chars.push_back(dtf_pkg::CH_MINUS);
        1: line_chars.push_back(dtf_pkg::CH_PLUS);
        default: begin
        end
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4);
      repeat (n) line_chars.push_back(pick_digit());
      if ($urandom_range(2) != 0) begin
        line_chars.push_back(dtf_pkg::CH_DOT);
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(9);
        repeat (n) line_chars.push_back(pick_digit());
      end
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(2, 1)) line_chars.push_back(pick_space());
      if (kind < 25 && line_chars.size() != 0)
        line_chars[$urandom_range(line_chars.size() - 1)] =
          dtf_pkg::CHAR_W'($urandom_range(255, 1));
    end
  endtask

  // offers one character, waits for its acceptance and records what it should produce
  task automatic send_char(input logic [dtf_pkg::CHAR_W-1:0] c, input bit typed,
                           input fixed_result_t typed_res);
    bit            done;
    fixed_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    do @(posedge clk); while (!char_ch.ready);
    parse_char(c, done, predicted);
    chars_sent++;
    if (done) begin
      pending_results.push_back(typed ? typed_res : predicted);
      strings_sent++;
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: compare each accepted item, then pick ready for the next edge
  initial begin
    int            hold_left;
    bit            seen_toggle;
    fixed_result_t want;
    res_ch.ready <= 1'b0;
    hold_left   = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: value %h", res_ch.value);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.valid_res) well_formed_seen++;
          if (want.overflow) overflow_seen++;
          if (res_ch.value !== want.value) begin
            $error("value mismatch: expected %h, actual %h", want.value, res_ch.value);
            fail_count++;
          end
          if (res_ch.valid_res !== want.valid_res) begin
            $error("valid_res mismatch: expected %b, actual %b", want.valid_res,
                   res_ch.valid_res);
            fail_count++;
          end
          if (res_ch.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %b, actual %b", want.overflow,
                   res_ch.overflow);
            fail_count++;
          end
        end
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // stimulus
  initial begin
    int phase_send[4];
    int phase_recv[4];
    int phase_start;
    phase_send = '{0, 70, 0, 23};
    phase_recv = '{0, 0, 70, 23};
    no_typed   = '{default: '0};
    fail_count = 0;
    chars_sent = 0;
    strings_sent = 0;
    results_checked = 0;
    well_formed_seen = 0;
    overflow_seen = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_toggle = 1'b0;
    clear_parser();
    rst               <= 1'b1;
    char_ch.valid     <= 1'b0;
    char_ch.char_code <= dtf_pkg::CH_NUL;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        send_char(dtf_pkg::CHAR_W'(directed_rows[r].text[i]), 1'b0, no_typed);
      send_char(dtf_pkg::CH_NUL, directed_rows[r].typed, directed_rows[r].res);
    end
    char_ch.valid <= 1'b0;
    drain_results();

    // random strings under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // long receiver hold-off while characters keep coming, so the input backs up
      if (p == 0) hold_toggle <= ~hold_toggle;
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_ITEMS) begin
        build_random_line();
        foreach (line_chars[i]) send_char(line_chars[i], 1'b0, no_typed);
        send_char(dtf_pkg::CH_NUL, 1'b0, no_typed);
      end
      char_ch.valid <= 1'b0;
      drain_results();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d strings in %0d characters: %0d well-formed, %0d saturated",
             strings_sent, chars_sent, well_formed_seen, overflow_seen);
    $display("four idle/stall mixes plus a long output hold-off; %0d results checked",
             results_checked);
    if (fail_count == 0) begin
      $display("decimal_text_to_fixed_point_unit test passed");
    end else begin
      $display("decimal_text_to_fixed_point_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/dtf_pkg.sv
rtl/core/dtf_if.sv
rtl/core/dtf_front.sv
rtl/core/dtf_queue.sv
rtl/core/dtf_back.sv
rtl/core/decimal_text_to_fixed_point_unit.sv
tb/decimal_text_to_fixed_point_unit_tb.sv
